// ===== hdl/pte_pkg.sv =====
`default_nettype none

package pte_pkg;

  // field widths of the transaction payloads
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDENT_W = 16;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned COUNT_W = 5;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SEEN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // result events
  localparam logic [EVENT_W-1:0] EV_ENTERED  = 3'd0;
  localparam logic [EVENT_W-1:0] EV_EXITED   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DONE     = 3'd2;
  localparam logic [EVENT_W-1:0] EV_READ     = 3'd3;
  localparam logic [EVENT_W-1:0] EV_OVERFLOW = 3'd4;
  localparam logic [EVENT_W-1:0] EV_BADPOS   = 3'd5;

  // ring control shared by every cell
  typedef struct packed {
    logic shift;
    logic bwd;
  } pte_ring_t;

endpackage

`default_nettype wire

// ===== hdl/pte_if.sv =====
`default_nettype none

interface pte_in_if;
  logic                        valid;
  logic                        ready;
  logic [pte_pkg::MODE_W-1:0]  mode;
  logic [pte_pkg::IDENT_W-1:0] ident;
  logic [pte_pkg::POS_W-1:0]   position;

  modport source (output valid, output mode, output ident, output position, input ready);
  modport sink   (input valid, input mode, input ident, input position, output ready);
endinterface

interface pte_out_if;
  logic                        valid;
  logic                        ready;
  logic [pte_pkg::EVENT_W-1:0] event_res;
  logic [pte_pkg::IDENT_W-1:0] ident_out;
  logic [pte_pkg::COUNT_W-1:0] present_count;
  logic                        last;

  modport source (output valid, output event_res, output ident_out, output present_count,
                  output last, input ready);
  modport sink   (input valid, input event_res, input ident_out, input present_count,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/pte_cell.sv =====
`default_nettype none

module pte_cell #(
  parameter int unsigned ID_BITS = 16
) (
  input  logic                clk_i,
  input  pte_pkg::pte_ring_t  ring_i,
  input  logic [ID_BITS-1:0]  prev_i,
  input  logic [ID_BITS-1:0]  next_i,
  input  logic [ID_BITS-1:0]  cmp_i,
  output logic [ID_BITS-1:0]  value_o,
  output logic                match_o
);
  import pte_pkg::*;

  logic [ID_BITS-1:0] value_q;
  logic [ID_BITS-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ring_i.shift) begin
      value_d = ring_i.bwd ? prev_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = (value_q == cmp_i);

endmodule

`default_nettype wire

// ===== hdl/pte_ctrl.sv =====
`default_nettype none

module pte_ctrl #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  pte_in_if.sink                  in_i,
  pte_out_if.source               out_o,
  input  logic [ID_BITS-1:0]      head_i,
  input  logic [ID_BITS-1:0]      tail_i,
  input  logic [TABLE_DEPTH-1:0]  match_i,
  output pte_pkg::pte_ring_t      ring_o,
  output logic [ID_BITS-1:0]      wb_o,
  output logic [ID_BITS-1:0]      cmp_o
);
  import pte_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FWD,
    ST_BWD,
    ST_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [ID_BITS-1:0]  id_q, id_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IW-1:0]       k_q, k_d;
  logic [CW-1:0]       ec_q, ec_d;
  logic [CW-1:0]       seen_q, seen_d;
  logic [CW-1:0]       found_q, found_d;
  logic [ID_BITS-1:0]  tmp_q, tmp_d;
  logic                emit_q, emit_d;
  logic [EVENT_W-1:0]  pend_ev_q, pend_ev_d;
  logic [ID_BITS-1:0]  pend_id_q, pend_id_d;
  logic [CW-1:0]       pend_cnt_q, pend_cnt_d;
  logic                ov_q, ov_d;
  logic [EVENT_W-1:0]  oev_q, oev_d;
  logic [IDENT_W-1:0]  oid_q, oid_d;
  logic [COUNT_W-1:0]  ocnt_q, ocnt_d;
  logic                olast_q, olast_d;

  logic [TABLE_DEPTH-1:0] seen_m, unseen_m;
  logic                   dup, hit;
  logic [IW-1:0]          idx;
  logic [CW-1:0]          k_ext, tail_pos;
  logic                   last_k, exit_hit, slot;
  logic [31:0]            in_id32;

  // search the seen and unseen regions at once; identifiers are unique in the table
  always_comb begin
    idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      seen_m[i]   = (CW'(i) < seen_q);
      unseen_m[i] = (CW'(i) >= seen_q) && (CW'(i) < ec_q);
      if (match_i[i] && unseen_m[i]) begin
        idx = idx | IW'(i);
      end
    end
    dup = |(match_i & seen_m);
    hit = |(match_i & unseen_m);
  end

  assign k_ext    = CW'(k_q);
  assign last_k   = (k_q == IW'(TABLE_DEPTH - 1));
  assign tail_pos = CW'(IW'(TABLE_DEPTH - 1) - k_q);
  assign exit_hit = (tail_pos >= seen_q) && (tail_pos < ec_q);
  assign slot     = !ov_q || out_o.ready;
  assign in_id32  = 32'(in_i.ident);

  always_comb begin
    logic                ld;
    logic [EVENT_W-1:0]  ld_ev;
    logic [ID_BITS-1:0]  ld_id;
    logic [CW-1:0]       ld_cnt;
    logic                ld_last;
    logic [31:0]         ld_id32;
    logic [7:0]          ld_cnt8;

    state_d    = state_q;
    mode_d     = mode_q;
    id_d       = id_q;
    pos_d      = pos_q;
    k_d        = k_q;
    ec_d       = ec_q;
    seen_d     = seen_q;
    found_d    = found_q;
    tmp_d      = tmp_q;
    emit_d     = emit_q;
    pend_ev_d  = pend_ev_q;
    pend_id_d  = pend_id_q;
    pend_cnt_d = pend_cnt_q;
    ov_d       = ov_q;
    oev_d      = oev_q;
    oid_d      = oid_q;
    ocnt_d     = ocnt_q;
    olast_d    = olast_q;
    ring_o     = '0;
    wb_o       = head_i;
    ld         = 1'b0;
    ld_ev      = pend_ev_q;
    ld_id      = pend_id_q;
    ld_cnt     = pend_cnt_q;
    ld_last    = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mode_d = in_i.mode;
          id_d   = in_id32[ID_BITS-1:0];
          pos_d  = in_i.position;
          k_d    = '0;
          unique case (in_i.mode)
            MODE_SEEN:  state_d = ST_SEARCH;
            MODE_FRAME: state_d = ST_BWD;
            MODE_READ: begin
              pend_cnt_d = ec_q;
              if (8'(in_i.position) < 8'(ec_q)) begin
                pend_ev_d = EV_READ;
                emit_d    = 1'b1;
                state_d   = ST_FWD;
              end else begin
                pend_ev_d = EV_BADPOS;
                pend_id_d = '0;
                state_d   = ST_EMIT;
              end
            end
            default: ;  // unused mode: drop the transaction
          endcase
        end
      end

      ST_SEARCH: begin
        priority if (dup) begin
          state_d = ST_IDLE;
        end else if (hit) begin
          found_d = CW'(idx);
          emit_d  = 1'b0;
          state_d = ST_FWD;
        end else if (ec_q == CW'(TABLE_DEPTH)) begin
          pend_ev_d  = EV_OVERFLOW;
          pend_id_d  = id_q;
          pend_cnt_d = ec_q;
          state_d    = ST_EMIT;
        end else begin
          // append at the end; the swap pass moves it to the seen boundary
          found_d    = ec_q;
          ec_d       = ec_q + 1'b1;
          pend_ev_d  = EV_ENTERED;
          pend_id_d  = id_q;
          pend_cnt_d = ec_q + 1'b1;
          emit_d     = 1'b1;
          state_d    = ST_FWD;
        end
      end

      ST_FWD: begin
        // head holds position k; the written-back value enters the far end
        ring_o.shift = 1'b1;
        if (mode_q == MODE_SEEN) begin
          if (k_ext == seen_q) begin
            wb_o  = id_q;
            tmp_d = head_i;
          end else if (k_ext == found_q) begin
            wb_o = tmp_q;
          end
        end else if (8'(k_q) == 8'(pos_q)) begin
          pend_id_d = head_i;
        end
        if (last_k) begin
          k_d = '0;
          if (mode_q == MODE_SEEN) begin
            seen_d = seen_q + 1'b1;
          end
          state_d = emit_q ? ST_EMIT : ST_IDLE;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      ST_BWD: begin
        // tail holds position N-1-k, so exits come out from the top down
        ring_o.bwd = 1'b1;
        if (!exit_hit || slot) begin
          ring_o.shift = 1'b1;
          if (exit_hit) begin
            ld      = 1'b1;
            ld_ev   = EV_EXITED;
            ld_id   = tail_i;
            ld_cnt  = tail_pos;
            ld_last = 1'b0;
          end
          if (last_k) begin
            k_d        = '0;
            pend_ev_d  = EV_DONE;
            pend_id_d  = '0;
            pend_cnt_d = seen_q;
            ec_d       = seen_q;
            seen_d     = '0;
            state_d    = ST_EMIT;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end

      ST_EMIT: begin
        if (slot) begin
          ld      = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    ld_id32 = 32'(ld_id);
    ld_cnt8 = 8'(ld_cnt);
    if (ld) begin
      ov_d    = 1'b1;
      oev_d   = ld_ev;
      oid_d   = ld_id32[IDENT_W-1:0];
      ocnt_d  = ld_cnt8[COUNT_W-1:0];
      olast_d = ld_last;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_SEEN;
      id_q       <= '0;
      pos_q      <= '0;
      k_q        <= '0;
      ec_q       <= '0;
      seen_q     <= '0;
      found_q    <= '0;
      tmp_q      <= '0;
      emit_q     <= 1'b0;
      pend_ev_q  <= EV_DONE;
      pend_id_q  <= '0;
      pend_cnt_q <= '0;
      ov_q       <= 1'b0;
      oev_q      <= EV_DONE;
      oid_q      <= '0;
      ocnt_q     <= '0;
      olast_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      id_q       <= id_d;
      pos_q      <= pos_d;
      k_q        <= k_d;
      ec_q       <= ec_d;
      seen_q     <= seen_d;
      found_q    <= found_d;
      tmp_q      <= tmp_d;
      emit_q     <= emit_d;
      pend_ev_q  <= pend_ev_d;
      pend_id_q  <= pend_id_d;
      pend_cnt_q <= pend_cnt_d;
      ov_q       <= ov_d;
      oev_q      <= oev_d;
      oid_q      <= oid_d;
      ocnt_q     <= ocnt_d;
      olast_q    <= olast_d;
    end
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = ov_q;
  assign out_o.event_res     = oev_q;
  assign out_o.ident_out     = oid_q;
  assign out_o.present_count = ocnt_q;
  assign out_o.last          = olast_q;
  assign cmp_o               = id_q;

  a_seen_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= ec_q)
    else $error("seen region larger than the table contents");

  a_count_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ec_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_SEARCH) |-> (k_q == '0))
    else $error("ring not back at home alignment");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && pend_ev_q == EV_DONE) |-> (seen_q == '0 && ec_q == pend_cnt_q))
    else $error("frame end left stale counts");

endmodule

`default_nettype wire

// ===== hdl/presence_tracker_enter_exit_unit.sv =====
// Channel  Dir  Payload                                     Transaction
// in_i     in   mode, ident, position                       valid && ready
// out_o    out  event_res, ident_out, present_count, last   valid && ready
//
// The table lives in a ring of TABLE_DEPTH cells that rotate as a whole.
// Sighting: accept, search, forward swap pass round the ring, emit for an entered result;
// a duplicate goes idle after the search, an overflow goes to the emit. End of frame:
// accept, backward pass round the ring, frame-done emit; read: accept, forward pass,
// emit; bad position: accept, emit. A full output register stalls the emit and, when
// an exit is due, the backward pass; results leave through one output register.
// Reset clears the counts; cell contents stay undefined until written.
`default_nettype none

module presence_tracker_enter_exit_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pte_in_if.sink    in_i,
  pte_out_if.source out_o
);
  import pte_pkg::*;

  pte_ring_t             ring;
  logic [ID_BITS-1:0]    wb;
  logic [ID_BITS-1:0]    cmp;
  logic [ID_BITS-1:0]    cell_val [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] nxt;
    if (g == TABLE_DEPTH - 1) begin : g_end
      assign nxt = wb;
    end else begin : g_mid
      assign nxt = cell_val[g+1];
    end

    pte_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .ring_i  (ring),
      .prev_i  (cell_val[(g + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .next_i  (nxt),
      .cmp_i   (cmp),
      .value_o (cell_val[g]),
      .match_o (match[g])
    );
  end

  pte_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .head_i  (cell_val[0]),
    .tail_i  (cell_val[TABLE_DEPTH-1]),
    .match_i (match),
    .ring_o  (ring),
    .wb_o    (wb),
    .cmp_o   (cmp)
  );

endmodule

`default_nettype wire
